// File: rtl/core/frame_bitmap_allocator_defines.svh
// assertion macros shared by the allocator
`ifndef FRAME_BITMAP_ALLOCATOR_DEFINES_SVH
`define FRAME_BITMAP_ALLOCATOR_DEFINES_SVH

// same-cycle implication on clk, off while arst_n is low
`define FBA_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication on clk, off while arst_n is low
`define FBA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/fba_pkg.sv
package fba_pkg;

	localparam int DEFAULT_MAX_FRAMES = 4096;
	localparam int WORD_BITS          = 32;
	localparam int BIT_W              = 5;
	localparam int PAGE_SHIFT         = 12;
	localparam int PFN_W              = 20;
	localparam int ADDR_W             = 32;
	localparam int FRAME_COUNT_W      = 13;
	localparam logic [FRAME_COUNT_W-1:0] FRAME_COUNT_RST = 13'd4096;
	localparam int S_TDATA_W          = 56;
	localparam int M_TDATA_W          = 24;

	typedef enum logic [1:0] {
		ST_DONE   = 2'd0,
		ST_MAPPED = 2'd1,
		ST_NOFREE = 2'd2,
		ST_RANGE  = 2'd3
	} status_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic    load;
		logic    clr_wr;
		logic    scan_start;
		logic    scan_rd;
		logic    claim_rd;
		logic    claim_wr;
		logic    hit_wr;
		logic    set_status;
		status_t status;
		logic    out_load;
	} dp_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic clr_last;
		logic mapped;
		logic claim;
		logic range;
		logic lim_zero;
		logic chk_valid;
		logic chk_found;
		logic chk_last;
		logic out_free;
	} dp_stat_t;

endpackage

// File: rtl/core/fba_ctrl.sv
module fba_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output fba_pkg::dp_cmd_t cmd,
	input  fba_pkg::dp_stat_t stat
);
	import fba_pkg::*;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DISPATCH,
		S_SCAN,
		S_CLAIM,
		S_RESULT
	} state_t;

	state_t state_q;
	state_t state_nxt;

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		cmd.status = ST_DONE;
		in_ready  = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (stat.clr_last) begin
					state_nxt = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				priority if (stat.mapped) begin
					cmd.set_status = 1'b1;
					cmd.status     = ST_MAPPED;
					state_nxt      = S_RESULT;
				end else if (stat.claim && stat.range) begin
					cmd.set_status = 1'b1;
					cmd.status     = ST_RANGE;
					state_nxt      = S_RESULT;
				end else if (stat.claim) begin
					cmd.claim_rd = 1'b1;
					state_nxt    = S_CLAIM;
				end else if (stat.lim_zero) begin
					cmd.set_status = 1'b1;
					cmd.status     = ST_NOFREE;
					state_nxt      = S_RESULT;
				end else begin
					cmd.scan_start = 1'b1;
					state_nxt      = S_SCAN;
				end
			end
			S_SCAN: begin
				priority if (stat.chk_valid && stat.chk_found) begin
					cmd.hit_wr     = 1'b1;
					cmd.set_status = 1'b1;
					cmd.status     = ST_DONE;
					state_nxt      = S_RESULT;
				end else if (stat.chk_valid && stat.chk_last) begin
					cmd.set_status = 1'b1;
					cmd.status     = ST_NOFREE;
					state_nxt      = S_RESULT;
				end else begin
					cmd.scan_rd = 1'b1;
				end
			end
			S_CLAIM: begin
				cmd.claim_wr   = 1'b1;
				cmd.set_status = 1'b1;
				cmd.status     = ST_DONE;
				state_nxt      = S_RESULT;
			end
			S_RESULT: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

// File: rtl/core/fba_dp.sv
module fba_dp #(
	parameter int MAX_FRAMES = fba_pkg::DEFAULT_MAX_FRAMES
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wen,
	input  logic [fba_pkg::FRAME_COUNT_W-1:0]   cfg_wdata,
	input  logic [fba_pkg::S_TDATA_W-1:0]       s_tdata,
	input  logic                                s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [fba_pkg::M_TDATA_W-1:0]       m_tdata,
	output logic [1:0]                          m_tuser,
	input  fba_pkg::dp_cmd_t                    cmd,
	output fba_pkg::dp_stat_t                   stat
);
	import fba_pkg::*;

	localparam int WORDS = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
	localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int LW    = ($clog2(MAX_FRAMES + 1) > FRAME_COUNT_W) ?
	                       $clog2(MAX_FRAMES + 1) : FRAME_COUNT_W;

	logic [FRAME_COUNT_W-1:0] fc_q;

	// captured item
	logic              cmd_q;
	logic              kern_q;
	logic              wr_q;
	logic [PFN_W-1:0]  exist_q;
	logic [PFN_W-1:0]  claim_frame_q;
	logic              lim_zero_q;
	logic [AW-1:0]     last_word_q;
	logic [WORD_BITS-1:0] last_mask_q;

	// scan and bitmap access
	logic [WORD_BITS-1:0] mem [WORDS];
	logic [AW-1:0]        addr_q;
	logic                 scan_end_q;
	logic                 rd_vld_s1;
	logic [AW-1:0]        rd_word_s1;
	logic [WORD_BITS-1:0] rdata_s1;

	// result and output register
	status_t              res_status_q;
	logic [PFN_W-1:0]     res_frame_q;
	logic                 m_valid_q;
	status_t              out_status_q;
	logic [PFN_W-1:0]     out_frame_q;
	logic                 out_present_q;
	logic                 out_writable_q;
	logic                 out_user_q;

	logic [LW-1:0]        fc_ext;
	logic [LW-1:0]        lim;
	logic [LW-1:0]        lim_m1;
	logic [AW-1:0]        claim_word;
	logic [BIT_W-1:0]     claim_bit;
	logic [WORD_BITS-1:0] free_bits;
	logic [BIT_W-1:0]     pe_bit;
	logic                 rd_en;
	logic [AW-1:0]        rd_addr;
	logic                 mem_we;
	logic [AW-1:0]        mem_wa;
	logic [WORD_BITS-1:0] mem_wd;
	logic [BIT_W-1:0]     wr_bit;
	logic [PFN_W-1:0]     hit_frame;
	logic                 res_done;

	// scan limit, saturated at the bitmap size
	always_comb begin
		fc_ext = LW'(fc_q);
		lim    = (fc_ext > LW'(MAX_FRAMES)) ? LW'(MAX_FRAMES) : fc_ext;
		lim_m1 = lim - LW'(1);
	end

	assign claim_word = claim_frame_q[AW+BIT_W-1:BIT_W];
	assign claim_bit  = claim_frame_q[BIT_W-1:0];

	// free frames of the word under check, cut at the limit in the last word
	assign free_bits = ~rdata_s1 & ((rd_word_s1 == last_word_q) ? last_mask_q : '1);

	always_comb begin
		pe_bit = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (free_bits[i]) begin
				pe_bit = BIT_W'(i);
			end
		end
	end

	assign hit_frame = PFN_W'({rd_word_s1, pe_bit});

	assign rd_en   = (cmd.scan_rd && !scan_end_q) || cmd.claim_rd;
	assign rd_addr = cmd.claim_rd ? claim_word : addr_q;
	assign mem_we  = cmd.clr_wr || cmd.claim_wr || cmd.hit_wr;
	assign mem_wa  = cmd.clr_wr ? addr_q : rd_word_s1;
	assign wr_bit  = cmd.claim_wr ? claim_bit : pe_bit;
	assign mem_wd  = cmd.clr_wr ? '0 : (rdata_s1 | (WORD_BITS'(1) << wr_bit));

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (rd_en) begin
			rdata_s1   <= mem[rd_addr];
			rd_word_s1 <= rd_addr;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fc_q       <= FRAME_COUNT_RST;
			addr_q     <= '0;
			scan_end_q <= 1'b0;
			rd_vld_s1  <= 1'b0;
			m_valid_q  <= 1'b0;
		end else begin
			if (cfg_wen) begin
				fc_q <= cfg_wdata;
			end
			if (cmd.clr_wr) begin
				addr_q <= addr_q + AW'(1);
			end else if (cmd.scan_start) begin
				addr_q     <= '0;
				scan_end_q <= 1'b0;
				rd_vld_s1  <= 1'b0;
			end else if (cmd.scan_rd) begin
				rd_vld_s1 <= !scan_end_q;
				if (!scan_end_q) begin
					addr_q     <= addr_q + AW'(1);
					scan_end_q <= (addr_q == last_word_q);
				end
			end
			if (cmd.out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// item capture, result and output payload
	assign res_done = (res_status_q == ST_DONE);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q         <= s_tuser;
			claim_frame_q <= s_tdata[ADDR_W-1:PAGE_SHIFT];
			kern_q        <= s_tdata[ADDR_W];
			wr_q          <= s_tdata[ADDR_W+1];
			exist_q       <= s_tdata[ADDR_W+2+PFN_W-1:ADDR_W+2];
			lim_zero_q    <= (lim == '0);
			last_word_q   <= lim_m1[AW+BIT_W-1:BIT_W];
			last_mask_q   <= {WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS - 1) - lim_m1[BIT_W-1:0]);
		end
		if (cmd.set_status) begin
			res_status_q <= cmd.status;
			unique case (cmd.status)
				ST_DONE:   res_frame_q <= cmd_q ? claim_frame_q : hit_frame;
				ST_MAPPED: res_frame_q <= exist_q;
				default:   res_frame_q <= '0;
			endcase
		end
		if (cmd.out_load) begin
			out_status_q   <= res_status_q;
			out_frame_q    <= res_frame_q;
			out_present_q  <= res_done;
			out_writable_q <= res_done && wr_q;
			out_user_q     <= res_done && !kern_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {1'b0, out_user_q, out_writable_q, out_present_q, out_frame_q};

	always_comb begin
		stat           = '0;
		stat.clr_last  = (addr_q == AW'(WORDS - 1));
		stat.mapped    = (exist_q != '0);
		stat.claim     = cmd_q;
		stat.range     = (claim_frame_q >= PFN_W'(MAX_FRAMES));
		stat.lim_zero  = lim_zero_q;
		stat.chk_valid = rd_vld_s1;
		stat.chk_found = |free_bits;
		stat.chk_last  = (rd_word_s1 == last_word_q);
		stat.out_free  = !m_valid_q || m_tready;
	end

endmodule

// File: rtl/core/frame_bitmap_allocator.sv
// paths: already mapped, out of range or empty limit go from dispatch to the result;
//   a claim rewrites its word; an allocation scans from word 0 to a free frame or the limit
// throughput: one item at a time, the next item is taken the cycle after the
//   result enters the output register; the allocation scan reads one word a cycle
// reset: arst_n clears control at once, then a clearing pass writes zero into
//   every bitmap word, one a cycle ((MAX_FRAMES+31)/32, 128 by default), s_tready low
`include "frame_bitmap_allocator_defines.svh"

module frame_bitmap_allocator #(
	parameter int MAX_FRAMES = fba_pkg::DEFAULT_MAX_FRAMES
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// frame_count write
	input  logic                              cfg_wen,
	input  logic [fba_pkg::FRAME_COUNT_W-1:0] cfg_wdata,
	// request item
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// byte_addr[31:0], kernel_page[32], rw_page[33], existing_frame[53:34], zero fill
	input  logic [fba_pkg::S_TDATA_W-1:0]     s_tdata,
	// cmd[0]
	input  logic                              s_tuser,
	// result item
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// frame_number[19:0], present[20], writable[21], user_access[22], zero fill
	output logic [fba_pkg::M_TDATA_W-1:0]     m_tdata,
	// status[1:0]
	output logic [1:0]                        m_tuser
);
	import fba_pkg::*;

	// controller sequences the clearing pass, dispatch, scan and read-modify-write
	dp_cmd_t  dp_cmd;
	dp_stat_t dp_stat;

	fba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.cmd      (dp_cmd),
		.stat     (dp_stat)
	);

	// datapath holds frame_count, the used-frame bitmap, the scan and the output register
	fba_dp #(
		.MAX_FRAMES (MAX_FRAMES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cmd       (dp_cmd),
		.stat      (dp_stat)
	);

	// only one item in flight at a time
	`FBA_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready, "item taken while busy")
	// a result never overwrites one still waiting
	`FBA_ASSERT_SAME(a_no_overwrite, dp_cmd.out_load, dp_stat.out_free, "result overwritten")
	// bitmap gets at most one write source per cycle
	`FBA_ASSERT_SAME(a_one_writer, 1'b1,
		$onehot0({dp_cmd.clr_wr, dp_cmd.claim_wr, dp_cmd.hit_wr}), "bitmap write clash")
	// page bits stay clear unless the command completed
	`FBA_ASSERT_SAME(a_flags_on_done, m_tvalid && (m_tuser != ST_DONE),
		m_tdata[22:20] == 3'b000, "page bits set on failed item")

endmodule

// File: verif/tb_frame_bitmap_allocator.sv
`timescale 1ns / 100ps

module tb_frame_bitmap_allocator;
	import fba_pkg::*;

	localparam int MAX_FRAMES = DEFAULT_MAX_FRAMES;
	localparam int MAP_WORDS  = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;

	// command codes carried on s_tuser
	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_CLAIM = 1'b1;

	// settling wait at the end, sized from the number of bitmap words
	localparam int SETTLE_CYCLES = MAP_WORDS + 12;

	typedef struct packed {
		logic              cmd;
		logic [ADDR_W-1:0] byte_addr;
		logic              kernel_page;
		logic              rw_page;
		logic [PFN_W-1:0]  existing_frame;
	} page_request_t;

	typedef struct packed {
		status_t          status;
		logic [PFN_W-1:0] frame_number;
		logic             present;
		logic             writable;
		logic             user_access;
	} page_entry_t;

	// frame bitmap shadow and the queue of page entries still to come out
	class frame_alloc_board;
		bit [WORD_BITS-1:0]       used_map [MAP_WORDS];
		logic [FRAME_COUNT_W-1:0] frame_count;
		page_entry_t              pending[$];
		int                       mismatches;

		function new();
			foreach (used_map[i])
				used_map[i] = '0;
			frame_count = FRAME_COUNT_RST;
			mismatches = 0;
		endfunction

		// lowest free frame below the saturated frame count
		function bit first_free(output logic [PFN_W-1:0] pfn);
			int limit;
			limit = (int'(frame_count) > MAX_FRAMES) ? MAX_FRAMES : int'(frame_count);
			pfn = '0;
			for (int f = 0; f < limit; f++) begin
				if (!used_map[f / WORD_BITS][f % WORD_BITS]) begin
					pfn = PFN_W'(f);
					return 1'b1;
				end
			end
			return 1'b0;
		endfunction

		function void note_request(page_request_t r);
			page_entry_t      e;
			logic [PFN_W-1:0] pfn;
			e = '{status: ST_DONE, frame_number: '0, present: 1'b0,
				writable: 1'b0, user_access: 1'b0};
			if (r.existing_frame != '0) begin
				// page already mapped wins over every other check
				e.status = ST_MAPPED;
				e.frame_number = r.existing_frame;
			end else if (r.cmd == CMD_ALLOC) begin
				if (first_free(pfn)) begin
					used_map[pfn >> BIT_W][pfn[BIT_W-1:0]] = 1'b1;
					e.frame_number = pfn;
				end else begin
					e.status = ST_NOFREE;
				end
			end else if ((r.byte_addr >> PAGE_SHIFT) >= MAX_FRAMES) begin
				e.status = ST_RANGE;
			end else begin
				// claim of a used frame is fine, the bit just stays set
				pfn = PFN_W'(r.byte_addr >> PAGE_SHIFT);
				used_map[pfn >> BIT_W][pfn[BIT_W-1:0]] = 1'b1;
				e.frame_number = pfn;
			end
			if (e.status == ST_DONE) begin
				e.present = 1'b1;
				e.writable = r.rw_page;
				e.user_access = ~r.kernel_page;
			end
			pending.push_back(e);
		endfunction

		task flag_mismatch(string what);
			mismatches++;
			$display("%0t mismatch: %s", $realtime, what);
		endtask

		task check_entry(page_entry_t got);
			page_entry_t want;
			if (pending.size() == 0) begin
				flag_mismatch($sformatf("unexpected item st=%s pfn=%h",
					got.status.name(), got.frame_number));
			end else begin
				want = pending.pop_front();
				if (got.status !== want.status || got.frame_number !== want.frame_number
						|| got.present !== want.present || got.writable !== want.writable
						|| got.user_access !== want.user_access)
					flag_mismatch($sformatf(
						"want st=%s pfn=%h p=%b rw=%b u=%b, got st=%0d pfn=%h p=%b rw=%b u=%b",
						want.status.name(), want.frame_number, want.present, want.writable,
						want.user_access, got.status, got.frame_number, got.present,
						got.writable, got.user_access));
			end
		endtask
	endclass

	logic                     clk;
	logic                     arst_n    = 1'b0;
	logic                     cfg_wen   = 1'b0;
	logic [FRAME_COUNT_W-1:0] cfg_wdata = '0;
	logic                     s_tvalid  = 1'b0;
	logic                     s_tready;
	// byte_addr[31:0], kernel_page[32], rw_page[33], existing_frame[53:34], zero fill
	logic [S_TDATA_W-1:0]     s_tdata   = '0;
	// cmd[0]
	logic                     s_tuser   = 1'b0;
	logic                     m_tvalid;
	logic                     m_tready  = 1'b0;
	// frame_number[19:0], present[20], writable[21], user_access[22], zero fill
	logic [M_TDATA_W-1:0]     m_tdata;
	// status[1:0]
	logic [1:0]               m_tuser;

	frame_alloc_board board;

	// idle odds in percent per cycle, and a long receiver hold-off in cycles
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_left = 0;
	// sequential claim sweep fills low frames so allocations scan deeper
	int sweep_frame = 0;

	frame_bitmap_allocator #(.MAX_FRAMES(MAX_FRAMES)) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// generous limit, far above the slowest legal run
	initial begin
		#20ms;
		$display("** frame_bitmap_allocator: FAILED **");
		$finish;
	end

	function automatic bit roll(int pct);
		return $urandom_range(0, 99) < pct;
	endfunction

	function automatic page_request_t mk_req(logic cmd, logic [ADDR_W-1:0] addr,
			logic kern, logic wr, logic [PFN_W-1:0] existing);
		page_request_t r;
		r.cmd = cmd;
		r.byte_addr = addr;
		r.kernel_page = kern;
		r.rw_page = wr;
		r.existing_frame = existing;
		return r;
	endfunction

	function automatic page_request_t rand_request();
		page_request_t r;
		int pick;
		r.cmd = 1'($urandom_range(0, 1));
		r.kernel_page = 1'($urandom_range(0, 1));
		r.rw_page = 1'($urandom_range(0, 1));
		r.existing_frame = '0;
		// a minority of pages are already mapped
		pick = $urandom_range(0, 99);
		if (pick < 3)
			r.existing_frame = '1;
		else if (pick < 5)
			r.existing_frame = 20'd1;
		else if (pick < 15)
			r.existing_frame = PFN_W'($urandom_range(1, (1 << PFN_W) - 1));
		// address: claims mostly inside the bitmap, some anywhere in the space; allocations anywhere
		pick = $urandom_range(0, 99);
		if (r.cmd == CMD_ALLOC || pick < 12) begin
			r.byte_addr = $urandom;
		end else if (pick < 50) begin
			r.byte_addr = (ADDR_W'(sweep_frame) << PAGE_SHIFT) | $urandom_range(0, 4095);
			sweep_frame = (sweep_frame + 1) % MAX_FRAMES;
		end else begin
			r.byte_addr = (ADDR_W'($urandom_range(0, MAX_FRAMES - 1)) << PAGE_SHIFT)
				| $urandom_range(0, 4095);
		end
		return r;
	endfunction

	function automatic page_entry_t unpack_entry(logic [M_TDATA_W-1:0] d, logic [1:0] u);
		page_entry_t e;
		e.status = status_t'(u);
		e.frame_number = d[PFN_W-1:0];
		e.present = d[20];
		e.writable = d[21];
		e.user_access = d[22];
		return e;
	endfunction

	// offer one item, with random idle cycles ahead of it, until it is taken
	task send_item(page_request_t r);
		while (roll(send_idle_pct)) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {2'b00, r.existing_frame, r.rw_page, r.kernel_page, r.byte_addr};
		s_tuser <= r.cmd;
		do
			@(posedge clk);
		while (!s_tready);
		board.note_request(r);
	endtask

	// stop offering and let every outstanding page entry come out
	task wait_drained();
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (board.pending.size() != 0);
		repeat (2) @(posedge clk);
	endtask

	task write_frame_count(logic [FRAME_COUNT_W-1:0] v);
		cfg_wen <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_wen <= 1'b0;
		board.frame_count = v;
	endtask

	task run_directed();
		wait_drained();
		write_frame_count(13'd4096);
		send_item(mk_req(CMD_ALLOC, 32'h0, 1'b0, 1'b0, 20'h0));
		send_item(mk_req(CMD_ALLOC, 32'hFFFF_FFFF, 1'b1, 1'b1, 20'h0));
		// already mapped, for an allocation and for a claim with an address outside the bitmap
		send_item(mk_req(CMD_ALLOC, 32'h0, 1'b0, 1'b1, 20'h1));
		send_item(mk_req(CMD_CLAIM, 32'hFFFF_FFFF, 1'b1, 1'b0, 20'hFFFFF));
		// claims far past the bitmap, at its last frame, just past it and at frame 2
		send_item(mk_req(CMD_CLAIM, 32'hFFFF_FFFF, 1'b0, 1'b1, 20'h0));
		send_item(mk_req(CMD_CLAIM, 32'h00FF_FFFF, 1'b0, 1'b1, 20'h0));
		send_item(mk_req(CMD_CLAIM, 32'h0100_0000, 1'b1, 1'b1, 20'h0));
		send_item(mk_req(CMD_CLAIM, 32'h0000_2FFF, 1'b1, 1'b0, 20'h0));
		// claims of frames already in use
		send_item(mk_req(CMD_CLAIM, 32'h0000_2000, 1'b0, 1'b0, 20'h0));
		send_item(mk_req(CMD_CLAIM, 32'h0000_0000, 1'b1, 1'b1, 20'h0));
		send_item(mk_req(CMD_ALLOC, 32'h0, 1'b0, 1'b1, 20'h0));
		// empty limit: nothing to allocate, but a claim above it is accepted
		wait_drained();
		write_frame_count(13'd0);
		send_item(mk_req(CMD_ALLOC, 32'h0, 1'b0, 1'b1, 20'h0));
		send_item(mk_req(CMD_CLAIM, 32'h0000_5000, 1'b0, 1'b1, 20'h0));
		// limit inside a partly used word, runs out after one allocation
		wait_drained();
		write_frame_count(13'd5);
		send_item(mk_req(CMD_ALLOC, 32'h0, 1'b1, 1'b0, 20'h0));
		send_item(mk_req(CMD_ALLOC, 32'h0, 1'b0, 1'b0, 20'h0));
		// limit beyond the bitmap saturates
		wait_drained();
		write_frame_count(13'h1FFF);
		send_item(mk_req(CMD_ALLOC, 32'h0, 1'b0, 1'b1, 20'h0));
		send_item(mk_req(CMD_CLAIM, 32'h00FF_F123, 1'b1, 1'b1, 20'h0));
	endtask

	task run_phase(int fc, int n, int send_pct, int stall_pct, int hold);
		wait_drained();
		write_frame_count((fc < 0) ? FRAME_COUNT_W'($urandom_range(0, (1 << FRAME_COUNT_W) - 1))
			: FRAME_COUNT_W'(fc));
		send_idle_pct = send_pct;
		recv_stall_pct = stall_pct;
		hold_left = hold;
		for (int i = 0; i < n; i++)
			send_item(rand_request());
	endtask

	// result side: check every taken item, then pick the next ready
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready)
				board.check_entry(unpack_entry(m_tdata, m_tuser));
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else begin
				m_tready <= !roll(recv_stall_pct);
			end
		end
	end

	initial begin
		// frame count per phase, -1 picks a random one
		int fc_plan[10]    = '{4096, 33, 8191, 32, 1, 31, 0, -1, 4096, -1};
		int send_plan[10]  = '{0, 54, 0, 35, 0, 54, 0, 35, 0, 54};
		int stall_plan[10] = '{0, 0, 54, 35, 0, 0, 54, 35, 0, 0};
		board = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		run_directed();
		for (int p = 0; p < 10; p++)
			// phase 2 holds the receiver off long enough to back up the input
			run_phase(fc_plan[p], 185, send_plan[p], stall_plan[p], (p == 2) ? 400 : 0);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (board.mismatches == 0)
			$display("** frame_bitmap_allocator: PASSED **");
		else
			$display("** frame_bitmap_allocator: FAILED **");
		$finish;
	end

endmodule
